// ===== sv/assert_macros.svh =====
// assertion macros used by the flux_interval_capture rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define FIC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define FIC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FIC_ASSERT(label, clk, rst_n, prop, msg)
`define FIC_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/fic_pkg.sv =====
// types and constants of the flux interval capture block
// no dependencies
`default_nettype none

package fic_pkg;

  localparam int unsigned CountBits = 20;
  localparam int unsigned TotalBits = 32;
  localparam int unsigned WordBits  = 16;
  localparam int unsigned WidthBits = 8;

  localparam logic [CountBits-1:0] BufLenReset   = 20'hFFFFF;
  localparam logic [TotalBits-1:0] CountLimReset = 32'd0;
  localparam logic                 RecIdxReset   = 1'b1;
  localparam logic [TotalBits-1:0] TotalMax      = 32'hFFFFFFFF;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BUFFER_LENGTH = 2'd0,
    REG_COUNT_LIMIT   = 2'd1,
    REG_RECORD_INDEX  = 2'd2
  } cfg_reg_e;

  // why a capture ended
  typedef enum logic [1:0] {
    STOP_NONE  = 2'd0,
    STOP_FULL  = 2'd1,
    STOP_LIMIT = 2'd2,
    STOP_INDEX = 2'd3
  } stop_e;

  typedef struct packed {
    logic                restart;
    logic                index_level;
    logic                sample_valid;
    logic [WordBits-1:0] sample_word;
  } in_t;

  typedef struct packed {
    logic                 pulse_valid;
    logic [WidthBits-1:0] pulse_width;
    logic [CountBits-1:0] pulse_position;
    logic                 index_event;
    logic [CountBits-1:0] index_offset;
    logic                 done_res;
    logic [1:0]           stop_reason;
  } out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  // capture control state, sample baseline kept apart
  typedef struct packed {
    logic                 baseline_taken;
    logic                 previous_index;
    logic                 finished;
    stop_e                end_cause;
    logic [CountBits-1:0] pulse_count;
    logic [TotalBits-1:0] interval_total;
  } ctl_t;

  // register settings seen by the step logic
  typedef struct packed {
    logic [CountBits-1:0] buffer_length;
    logic [TotalBits-1:0] count_limit;
    logic                 record_index;
  } regs_t;

endpackage

`default_nettype wire

// ===== sv/fic_stream_if.sv =====
// valid/ready channel carrying one beat of any payload type
// payload types come from fic_pkg
`default_nettype none

interface fic_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/fic_step.sv =====
// one tick of the capture: restart, buffer check, index edge, sample
// depends on fic_pkg
`default_nettype none

module fic_step
  import fic_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned PULSE_MAX   = 255
) (
  input  in_t                    item_i,
  input  regs_t                  regs_i,
  input  ctl_t                   ctl_i,
  input  logic [SAMPLE_BITS-1:0] prev_sample_i,
  output ctl_t                   ctl_o,
  output logic [SAMPLE_BITS-1:0] prev_sample_o,
  output out_t                   res_o
);

  localparam logic [31:0] PulseMax = 32'(PULSE_MAX);

  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] diff;
  logic [31:0]            delta;
  logic [32:0]            sum;
  logic [CountBits-1:0]   cnt_inc;

  // modular interval, halved
  assign smp   = SAMPLE_BITS'(32'(item_i.sample_word));
  assign diff  = prev_sample_i - smp;
  assign delta = 32'(diff[SAMPLE_BITS-1:1]);

  always_comb begin
    ctl_o         = ctl_i;
    prev_sample_o = prev_sample_i;
    res_o         = '0;
    sum           = '0;
    cnt_inc       = '0;

    // restart clears everything and latches the index level
    if (item_i.restart) begin
      ctl_o.baseline_taken = 1'b0;
      ctl_o.previous_index = item_i.index_level;
      ctl_o.finished       = 1'b0;
      ctl_o.end_cause      = STOP_NONE;
      ctl_o.pulse_count    = '0;
      ctl_o.interval_total = '0;
      prev_sample_o        = '0;
    end

    // buffer already full
    if (!ctl_o.finished && ctl_o.pulse_count >= regs_i.buffer_length) begin
      ctl_o.finished  = 1'b1;
      ctl_o.end_cause = STOP_FULL;
    end

    // index falling edge
    if (!ctl_o.finished) begin
      if (ctl_o.previous_index && !item_i.index_level && regs_i.record_index) begin
        res_o.index_event  = 1'b1;
        res_o.index_offset = ctl_o.pulse_count;
        if (regs_i.count_limit == '0) begin
          ctl_o.finished  = 1'b1;
          ctl_o.end_cause = STOP_INDEX;
        end
      end
      ctl_o.previous_index = item_i.index_level;
    end

    // sample: baseline first, then one pulse per sample
    if (!ctl_o.finished && item_i.sample_valid) begin
      prev_sample_o = smp;
      if (!ctl_o.baseline_taken) begin
        ctl_o.baseline_taken = 1'b1;
      end else begin
        sum     = {1'b0, ctl_o.interval_total} + {1'b0, delta};
        cnt_inc = ctl_o.pulse_count + CountBits'(1);
        ctl_o.interval_total = sum[32] ? TotalMax : sum[31:0];
        res_o.pulse_valid    = 1'b1;
        res_o.pulse_width    = (delta > PulseMax) ? PulseMax[WidthBits-1:0]
                                                  : delta[WidthBits-1:0];
        res_o.pulse_position = ctl_o.pulse_count;
        ctl_o.pulse_count    = cnt_inc;
        if (regs_i.count_limit != '0 && ctl_o.interval_total >= regs_i.count_limit) begin
          ctl_o.finished  = 1'b1;
          ctl_o.end_cause = STOP_LIMIT;
        end else if (cnt_inc >= regs_i.buffer_length) begin
          ctl_o.finished  = 1'b1;
          ctl_o.end_cause = STOP_FULL;
        end
      end
    end

    res_o.done_res    = ctl_o.finished;
    res_o.stop_reason = ctl_o.end_cause;
  end

endmodule

`default_nettype wire

// ===== sv/flux_interval_capture.sv =====
// flux interval capture: an input beat passes the input register, then the result
// register, before it leaves as a result beat; one beat accepted every cycle
// while the result side keeps taking beats. a stalled result holds both stages.
// reset clears capture state and loads register defaults: buffer_length
// 1048575, count_limit 0, record_index 1. no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module flux_interval_capture
  import fic_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned PULSE_MAX   = 255
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  fic_stream_if.sink    cfg_i,
  fic_stream_if.sink    in_i,
  fic_stream_if.source  out_o
);

  regs_t                  regs_q;
  in_t                    in_q;
  logic                   in_vld_q;
  ctl_t                   ctl_q, ctl_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  out_t                   out_q, res_d;
  logic                   out_vld_q;
  logic                   adv;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.buffer_length <= BufLenReset;
      regs_q.count_limit   <= CountLimReset;
      regs_q.record_index  <= RecIdxReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_BUFFER_LENGTH: regs_q.buffer_length <= cfg_i.data.data[CountBits-1:0];
        REG_COUNT_LIMIT:   regs_q.count_limit   <= cfg_i.data.data;
        REG_RECORD_INDEX:  regs_q.record_index  <= cfg_i.data.data[0];
        default: ;
      endcase
    end
  end

  // handshake: input stage moves on when the result stage is free
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  fic_step #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PULSE_MAX   (PULSE_MAX)
  ) u_step (
    .item_i        (in_q),
    .regs_i        (regs_q),
    .ctl_i         (ctl_q),
    .prev_sample_i (prev_q),
    .ctl_o         (ctl_d),
    .prev_sample_o (prev_d),
    .res_o         (res_d)
  );

  // capture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.baseline_taken <= 1'b0;
      ctl_q.previous_index <= 1'b1;
      ctl_q.finished       <= 1'b0;
      ctl_q.end_cause      <= STOP_NONE;
      ctl_q.pulse_count    <= '0;
      ctl_q.interval_total <= '0;
      prev_q               <= '0;
    end else if (adv) begin
      ctl_q  <= ctl_d;
      prev_q <= prev_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // checks on the state and stage logic
  `FIC_ASSERT(a_fin_hold, clk_i, rst_ni, (ctl_q.finished && !(adv && in_q.restart)) |=> ctl_q.finished, "capture left finished without restart")
  `FIC_ASSERT(a_state_idle, clk_i, rst_ni, !adv |=> ($stable(ctl_q) && $stable(prev_q)), "state changed with no beat processed")
  `FIC_ASSERT(a_count_step, clk_i, rst_ni, (adv && res_d.pulse_valid) |=> (ctl_q.pulse_count == CountBits'($past(res_d.pulse_position) + CountBits'(1))), "pulse count not one past position")
  `FIC_ASSERT(a_in_hold, clk_i, rst_ni, (in_vld_q && !adv) |=> (in_vld_q && $stable(in_q)), "held input beat lost")
  `FIC_NEVER(a_done_pulse, clk_i, rst_ni, out_vld_q && out_q.pulse_valid && out_q.done_res && out_q.stop_reason == STOP_INDEX, "pulse reported on an index stop")

endmodule

`default_nettype wire

// ===== dv/tb_flux_interval_capture.sv =====
// testbench for flux_interval_capture: directed and random ticks checked against a local predictor
// depends on fic_pkg, fic_stream_if and the flux_interval_capture rtl
`timescale 1ns / 1ps

module tb_flux_interval_capture;
  import fic_pkg::*;

  localparam int unsigned   MaxCycles   = 1000000;
  localparam int unsigned   Settle      = 4;
  localparam int unsigned   LongPulses  = 100;
  localparam logic [31:0]   LongLimit   = 32'd2949030;
  localparam logic [15:0]   PulseMax    = 16'd255;
  localparam logic [1:0]    RegSpare    = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  fic_stream_if #(.T(cfg_t)) cfg_if ();
  fic_stream_if #(.T(in_t))  in_if ();
  fic_stream_if #(.T(out_t)) out_if ();

  flux_interval_capture #(
    .SAMPLE_BITS(16),
    .PULSE_MAX  (255)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and capture state of the predictor
  logic [19:0] buf_len_m;
  logic [31:0] cnt_lim_m;
  logic        rec_idx_m;
  logic        base_taken_m;
  logic [15:0] prev_word_m;
  logic        prev_level_m;
  logic [31:0] total_m;
  logic [19:0] count_m;
  logic        done_m;
  stop_e       cause_m;

  out_t        expected_ticks[$];
  int          err_count     = 0;
  int          beats_checked = 0;
  int unsigned cycle_count   = 0;
  logic        no_gaps       = 1'b0;

  // stimulus generator state
  logic [15:0] gen_word;
  logic        gen_level;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic in_t tick_of(input logic rs, input logic lv, input logic sv,
                                  input logic [15:0] w);
    in_t t;
    t.restart      = rs;
    t.index_level  = lv;
    t.sample_valid = sv;
    t.sample_word  = w;
    return t;
  endfunction

  function automatic void clear_capture_m();
    base_taken_m = 1'b0;
    prev_word_m  = '0;
    prev_level_m = 1'b1;
    total_m      = '0;
    count_m      = '0;
    done_m       = 1'b0;
    cause_m      = STOP_NONE;
  endfunction

  function automatic void end_capture(input stop_e why);
    done_m  = 1'b1;
    cause_m = why;
  endfunction

  // one tick of the capture logic, queues the result it gives
  function automatic void predict_tick(input in_t t);
    out_t        r;
    logic        falling;
    logic [15:0] diff;
    logic [15:0] half;
    logic [32:0] sum;
    r = '0;
    if (t.restart) begin
      clear_capture_m();
      prev_level_m = t.index_level;
    end
    if (!done_m && count_m >= buf_len_m) end_capture(STOP_FULL);
    // index falling edge
    if (!done_m) begin
      falling      = prev_level_m && !t.index_level;
      prev_level_m = t.index_level;
      if (falling && rec_idx_m) begin
        r.index_event  = 1'b1;
        r.index_offset = count_m;
        if (cnt_lim_m == '0) end_capture(STOP_INDEX);
      end
    end
    // counter sample
    if (!done_m && t.sample_valid) begin
      if (!base_taken_m) begin
        base_taken_m = 1'b1;
        prev_word_m  = t.sample_word;
      end else begin
        diff             = prev_word_m - t.sample_word;
        half             = diff >> 1;
        sum              = {1'b0, total_m} + {17'd0, half};
        prev_word_m      = t.sample_word;
        total_m          = sum[32] ? TotalMax : sum[31:0];
        r.pulse_valid    = 1'b1;
        r.pulse_width    = (half > PulseMax) ? PulseMax[7:0] : half[7:0];
        r.pulse_position = count_m;
        count_m          = count_m + 1'b1;
        if (cnt_lim_m != '0 && total_m >= cnt_lim_m) end_capture(STOP_LIMIT);
        else if (count_m >= buf_len_m) end_capture(STOP_FULL);
      end
    end
    r.done_res    = done_m;
    r.stop_reason = cause_m;
    expected_ticks.push_back(r);
  endfunction

  // one input beat, predicted once accepted
  task automatic send_tick(input in_t t);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.data  <= t;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_tick(t);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_if.data  <= {idx, value};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_BUFFER_LENGTH: buf_len_m = value[19:0];
      REG_COUNT_LIMIT:   cnt_lim_m = value;
      REG_RECORD_INDEX:  rec_idx_m = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // stop sending and wait for every pending result
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  // mostly well-formed flux with an index line, some restarts and some noise
  function automatic in_t random_tick();
    in_t         t;
    int          pick;
    logic [31:0] bits;
    logic [15:0] delta;
    pick = $urandom_range(0, 99);
    bits = $urandom;
    t    = '0;
    if (pick < 8) begin
      t = bits[$bits(in_t)-1:0];
    end else if (pick < 11) begin
      t         = tick_of(1'b1, bits[16], bits[17], bits[15:0]);
      gen_level = t.index_level;
      gen_word  = t.sample_word;
    end else begin
      if ($urandom_range(0, 15) == 0) gen_level = !gen_level;
      t.index_level  = gen_level;
      t.sample_valid = ($urandom_range(0, 3) != 0);
      t.sample_word  = bits[15:0];
      if (t.sample_valid) begin
        delta         = ($urandom_range(0, 4) == 0) ? bits[31:16]
                                                    : 16'($urandom_range(0, 600));
        gen_word      = gen_word - delta;
        t.sample_word = gen_word;
      end
    end
    return t;
  endfunction

  task automatic run_random_phase(input logic [19:0] len, input logic [31:0] lim,
                                  input logic rec, input int n_ticks);
    logic [31:0] junk;
    settle();
    junk = $urandom;
    write_reg(REG_BUFFER_LENGTH, {junk[31:20], len});
    write_reg(REG_COUNT_LIMIT, lim);
    write_reg(REG_RECORD_INDEX, {junk[31:1], rec});
    gen_level = 1'b1;
    gen_word  = 16'($urandom);
    send_tick(tick_of(1'b1, 1'b1, 1'b1, gen_word));
    for (int k = 0; k < n_ticks; k++) begin
      if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
      send_tick(random_tick());
    end
    no_gaps = 1'b0;
  endtask

  // widths at the edges of the 16-bit wrap and of saturation, reset defaults
  task automatic test_pulse_widths();
    send_tick(tick_of(1'b0, 1'b1, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h0000));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'hFFFF));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'hFFFD));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'hFDFF));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'hFBFF));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'hFBFF));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h7BFF));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h7C00));
  endtask

  // index edges: stopping, before baseline, after restart, unrecorded, with a limit
  task automatic test_index_stop();
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 16'h1234));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h0000));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 1'b0, 1'b0, 16'h0000));
    send_tick(tick_of(1'b1, 1'b0, 1'b1, 16'h5555));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h5550));
    settle();
    write_reg(RegSpare, 32'hFFFFFFFF);
    write_reg(REG_RECORD_INDEX, 32'd0);
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 16'h5540));
    settle();
    write_reg(REG_COUNT_LIMIT, 32'd10);
    write_reg(REG_RECORD_INDEX, 32'd1);
    send_tick(tick_of(1'b0, 1'b1, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 16'h5530));
  endtask

  // buffer full, both limits on one pulse, buffer lowered mid-capture, zero buffer
  task automatic test_buffer_limits();
    settle();
    write_reg(REG_BUFFER_LENGTH, 32'd2);
    write_reg(REG_COUNT_LIMIT, 32'd0);
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 16'h0100));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h00F0));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h00E0));
    settle();
    write_reg(REG_COUNT_LIMIT, 32'd16);
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 16'h0100));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h00F0));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h00E0));
    settle();
    write_reg(REG_COUNT_LIMIT, 32'd0);
    write_reg(REG_BUFFER_LENGTH, {12'd0, BufLenReset});
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 16'h0100));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h00F0));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'h00E0));
    settle();
    write_reg(REG_BUFFER_LENGTH, 32'd1);
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 16'h00D0));
    settle();
    write_reg(REG_BUFFER_LENGTH, 32'd0);
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 16'h0000));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 16'hFFFF));
  endtask

  // longest pulses back to back until the total meets a large limit exactly
  task automatic test_long_pulses();
    logic [15:0] w;
    settle();
    write_reg(REG_BUFFER_LENGTH, {12'd0, BufLenReset});
    write_reg(REG_COUNT_LIMIT, LongLimit);
    write_reg(REG_RECORD_INDEX, 32'd0);
    no_gaps = 1'b1;
    w       = 16'h0000;
    send_tick(tick_of(1'b1, 1'b1, 1'b1, w));
    for (int k = 0; k < LongPulses; k++) begin
      w = w + 1'b1;
      send_tick(tick_of(1'b0, 1'b1, 1'b1, w));
    end
    no_gaps = 1'b0;
  endtask

  // random flux over several register settings
  task automatic test_random();
    run_random_phase(BufLenReset, 32'd0, 1'b1, 200);
    run_random_phase(20'd1, 32'd0, 1'b0, 150);
    run_random_phase(20'($urandom_range(1, 64)), $urandom_range(1, 20000), 1'b1, 200);
    run_random_phase(BufLenReset, TotalMax, 1'b0, 200);
    run_random_phase(20'($urandom_range(2, 2000)), $urandom_range(1, 100000),
                     1'($urandom_range(0, 1)), 250);
    run_random_phase(20'($urandom_range(1, 16)), 32'd0, 1'b1, 200);
  endtask

  // result side: random stalls between beats
  initial begin : result_sink
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("beat %0d %s: got %0h, want %0h", beats_checked, name, got, want));
  endtask

  // compare each result beat with the oldest prediction
  out_t got_tick;
  out_t want_tick;
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got_tick = out_if.data;
      if (expected_ticks.size() == 0) begin
        flag_error($sformatf("beat %0d arrived with nothing pending", beats_checked));
      end else begin
        want_tick = expected_ticks.pop_front();
        check_field("pulse_valid", 32'(got_tick.pulse_valid),
                    32'(want_tick.pulse_valid));
        check_field("pulse_width", 32'(got_tick.pulse_width),
                    32'(want_tick.pulse_width));
        check_field("pulse_position", 32'(got_tick.pulse_position),
                    32'(want_tick.pulse_position));
        check_field("index_event", 32'(got_tick.index_event),
                    32'(want_tick.index_event));
        check_field("index_offset", 32'(got_tick.index_offset),
                    32'(want_tick.index_offset));
        check_field("done_res", 32'(got_tick.done_res), 32'(want_tick.done_res));
        check_field("stop_reason", 32'(got_tick.stop_reason),
                    32'(want_tick.stop_reason));
      end
      beats_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycles) begin
      flag_error("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    buf_len_m    = BufLenReset;
    cnt_lim_m    = CountLimReset;
    rec_idx_m    = RecIdxReset;
    gen_word     = '0;
    gen_level    = 1'b1;
    clear_capture_m();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pulse_widths();
    test_index_stop();
    test_buffer_limits();
    test_long_pulses();
    test_random();
    settle();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fic_pkg.sv
sv/fic_stream_if.sv
sv/fic_step.sv
sv/flux_interval_capture.sv
dv/tb_flux_interval_capture.sv
